### rtl/core/mctu_pkg.sv
// ----------------------------------------------------------------------------
// mctu_pkg
// Shared types and constants of the multichannel compare timer unit:
// transaction structs, request codes, controller states and command bundle.
// ----------------------------------------------------------------------------
package mctu_pkg;

    localparam int unsigned REQ_BITS     = 2;
    localparam int unsigned CH_BITS      = 3;
    localparam int unsigned DUR_BITS     = 16;
    localparam int unsigned MASK_BITS    = 7;
    localparam int unsigned CNT_OUT_BITS = 16;

    localparam logic [REQ_BITS-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_START = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_STOP  = 2'd2;

    typedef struct packed {
        logic [REQ_BITS-1:0] req_type;
        logic [CH_BITS-1:0]  channel;
        logic [DUR_BITS-1:0] duration;
        logic                periodic;
    } t_req;

    typedef struct packed {
        logic [MASK_BITS-1:0]    fired_mask;
        logic [MASK_BITS-1:0]    active_mask;
        logic [CNT_OUT_BITS-1:0] current_count;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

### rtl/core/mctu_ctrl.sv
// ----------------------------------------------------------------------------
// mctu_ctrl
// Controller of the compare timer: captures a request, runs the execute
// state in the datapath and strobes the result for one cycle.
// ----------------------------------------------------------------------------
module mctu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output mctu_pkg::t_cmd o_cmd
);
    import mctu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (start) begin
                    n_state = S_EXEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy       = (r_state == S_EXEC);
        o_valid    = (r_state == S_RESP);
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.load = start && (r_state != S_EXEC);
    end

endmodule

### rtl/core/mctu_dpath.sv
// ----------------------------------------------------------------------------
// mctu_dpath
// Datapath of the compare timer: tick-driven counter, per-channel compare,
// period, mode and enable registers, and the result registers.
// ----------------------------------------------------------------------------
module mctu_dpath #(
    parameter int unsigned CHANNELS   = 7,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mctu_pkg::t_cmd i_cmd,
    input  mctu_pkg::t_req i_req,
    output mctu_pkg::t_rsp o_rsp
);
    import mctu_pkg::*;

    t_req                  r_req;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] r_cmp [CHANNELS];
    logic [COUNT_BITS-1:0] r_per [CHANNELS];
    logic [CHANNELS-1:0]   r_mode;
    logic [CHANNELS-1:0]   r_en;
    logic [CHANNELS-1:0]   r_fired;

    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] n_cmp [CHANNELS];
    logic [COUNT_BITS-1:0] n_per [CHANNELS];
    logic [CHANNELS-1:0]   n_mode;
    logic [CHANNELS-1:0]   n_en;
    logic [CHANNELS-1:0]   n_fired;

    logic [COUNT_BITS-1:0] w_inc;
    logic [COUNT_BITS-1:0] w_dur;

    assign w_inc = COUNT_BITS'(r_count + 1'b1);
    assign w_dur = COUNT_BITS'(r_req.duration);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    always_comb begin
        n_count = r_count;
        n_cmp   = r_cmp;
        n_per   = r_per;
        n_mode  = r_mode;
        n_en    = r_en;
        n_fired = '0;
        case (r_req.req_type)
            REQ_TICK: begin
                n_count = w_inc;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_en[i] && (r_cmp[i] == w_inc)) begin
                        n_fired[i] = 1'b1;
                        if (r_mode[i]) begin
                            n_cmp[i] = COUNT_BITS'(r_cmp[i] + r_per[i]);
                        end else begin
                            n_en[i]  = 1'b0;
                            n_cmp[i] = '0;
                        end
                    end
                end
            end
            REQ_START: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(r_req.channel) == i) begin
                        n_per[i]  = w_dur;
                        n_mode[i] = r_req.periodic;
                        n_cmp[i]  = COUNT_BITS'(r_count + w_dur);
                        n_en[i]   = 1'b1;
                    end
                end
            end
            REQ_STOP: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(r_req.channel) == i) begin
                        n_per[i] = '0;
                        n_cmp[i] = '0;
                        n_en[i]  = 1'b0;
                    end
                end
            end
            default: begin
                n_fired = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= '0;
            r_en    <= '0;
            r_fired <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cmp[i] <= '0;
                r_per[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_cmp   <= n_cmp;
            r_per   <= n_per;
            r_mode  <= n_mode;
            r_en    <= n_en;
            r_fired <= n_fired;
        end
    end

    assign o_rsp.fired_mask    = MASK_BITS'(r_fired);
    assign o_rsp.active_mask   = MASK_BITS'(r_en);
    assign o_rsp.current_count = CNT_OUT_BITS'(r_count);

    // only channels enabled before the step may fire
    a_fired_was_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> ((r_fired & ~$past(r_en)) == '0))
        else $error("channel fired while disabled");

    // start, stop and unused codes report no expiry
    a_no_fire_off_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_req.req_type != REQ_TICK)) |=> (r_fired == '0))
        else $error("fired mask set on non-tick transaction");

    // counter holds outside tick transactions
    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_req.req_type != REQ_TICK)) |=> $stable(r_count))
        else $error("counter moved on non-tick transaction");

    // tick advances the counter by one
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_req.req_type == REQ_TICK))
            |=> (r_count == COUNT_BITS'($past(r_count) + 1'b1)))
        else $error("counter did not advance on tick");

endmodule

### rtl/core/multichannel_compare_timer_unit.sv
// ----------------------------------------------------------------------------
// multichannel_compare_timer_unit
// Tick-driven counter shared by compare channels with one-shot and periodic
// expiry; start, stop and tick requests, one result per transaction.
// Result strobed on o_valid once execute has updated the result registers.
// A new request is taken while a result is strobed, not during execute.
// busy is high only in the execute cycle; the receiver cannot stall results.
// Synchronous active-low reset clears the counter and all channel state.
// ----------------------------------------------------------------------------
module multichannel_compare_timer_unit #(
    parameter int unsigned CHANNELS   = 7,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mctu_pkg::t_req i_req,
    output logic           o_valid,
    output mctu_pkg::t_rsp o_rsp
);
    import mctu_pkg::*;

    t_cmd w_cmd;

    mctu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    mctu_dpath #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

### sim/multichannel_compare_timer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_compare_timer_unit_tb
// Self-checking bench for the compare timer unit. Start, stop, tick and
// unused requests go in over the start/busy handshake; a behavioural model of
// the counter and the seven compare channels predicts each response, and a
// monitor checks every strobed response in order. Directed tests cover the
// unused request code, out-of-range channels, restart, stop of an idle
// channel, one-shot and periodic expiry and zero and full-range durations;
// random traffic follows with varying sender gaps.
// ----------------------------------------------------------------------------
module multichannel_compare_timer_unit_tb;

    import mctu_pkg::*;

    localparam int unsigned    NUM_CH     = 7;
    localparam logic [1:0]     REQ_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    // timer model state
    logic [15:0]       model_count;
    logic [15:0]       chan_compare [NUM_CH];
    logic [15:0]       chan_period  [NUM_CH];
    logic [NUM_CH-1:0] chan_periodic;
    logic [NUM_CH-1:0] chan_enabled;

    t_rsp        expected_rsp [$];
    int unsigned error_count = 0;

    multichannel_compare_timer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic void clear_timer_model();
        model_count   = '0;
        chan_periodic = '0;
        chan_enabled  = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            chan_compare[ch] = '0;
            chan_period[ch]  = '0;
        end
    endfunction

    function automatic t_rsp predict_timer_step(input t_req req);
        t_rsp              rsp;
        logic [NUM_CH-1:0] fired;
        fired = '0;
        case (req.req_type)
            REQ_TICK: begin
                model_count = model_count + 16'd1;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (chan_enabled[ch] && chan_compare[ch] == model_count) begin
                        fired[ch] = 1'b1;
                        if (chan_periodic[ch]) begin
                            chan_compare[ch] = chan_compare[ch] + chan_period[ch];
                        end else begin
                            chan_enabled[ch] = 1'b0;
                            chan_compare[ch] = '0;
                        end
                    end
                end
            end
            REQ_START: begin
                if (req.channel < NUM_CH) begin
                    chan_period[req.channel]   = req.duration;
                    chan_periodic[req.channel] = req.periodic;
                    chan_compare[req.channel]  = model_count + req.duration;
                    chan_enabled[req.channel]  = 1'b1;
                end
            end
            REQ_STOP: begin
                if (req.channel < NUM_CH) begin
                    chan_period[req.channel]  = '0;
                    chan_compare[req.channel] = '0;
                    chan_enabled[req.channel] = 1'b0;
                end
            end
            default: ;
        endcase
        rsp.fired_mask    = fired;
        rsp.active_mask   = chan_enabled;
        rsp.current_count = model_count;
        return rsp;
    endfunction

    // one transaction: hold start until the edge that accepts it
    task automatic send_req(input t_req req);
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_rsp.push_back(predict_timer_step(req));
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [2:0] ch,
                               input logic [15:0] dur, input logic per);
        t_req req;
        req.req_type = kind;
        req.channel  = ch;
        req.duration = dur;
        req.periodic = per;
        send_req(req);
    endtask

    function automatic t_req random_req();
        t_req        req;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            req.req_type = REQ_TICK;
        end else if (pick < 80) begin
            req.req_type = REQ_START;
        end else if (pick < 94) begin
            req.req_type = REQ_STOP;
        end else begin
            req.req_type = REQ_UNUSED;
        end
        req.channel = 3'($urandom_range(7));
        pick = $urandom_range(15);
        if (pick < 2) begin
            req.duration = 16'($urandom_range(16'hFFFF));
        end else if (pick == 2) begin
            req.duration = '0;
        end else begin
            req.duration = 16'($urandom_range(1, 24));
        end
        req.periodic = 1'($urandom_range(1));
        return req;
    endfunction

    task automatic pause_sender(input int unsigned pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            i_req <= random_req();
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_unused_requests();
        send_fields(REQ_UNUSED, 3'd7, 16'hFFFF, 1'b1);
        send_fields(REQ_START, 3'd7, 16'd5, 1'b1);
        send_fields(REQ_STOP, 3'd7, 16'd0, 1'b0);
        send_fields(REQ_UNUSED, 3'd0, 16'd0, 1'b0);
    endtask

    task automatic test_expiry_modes();
        send_fields(REQ_START, 3'd0, 16'd2, 1'b0);
        send_fields(REQ_START, 3'd6, 16'd3, 1'b1);
        send_fields(REQ_START, 3'd1, 16'd1, 1'b1);
        repeat (4) send_fields(REQ_TICK, 3'd0, 16'd0, 1'b0);
        // restart a running channel as one-shot
        send_fields(REQ_START, 3'd6, 16'd1, 1'b0);
        send_fields(REQ_TICK, 3'd5, 16'hFFFF, 1'b1);
        send_fields(REQ_STOP, 3'd5, 16'hFFFF, 1'b1);
        send_fields(REQ_STOP, 3'd1, 16'd0, 1'b0);
        repeat (2) send_fields(REQ_TICK, 3'd0, 16'd0, 1'b0);
    endtask

    task automatic test_long_durations();
        send_fields(REQ_START, 3'd2, 16'd0, 1'b1);
        send_fields(REQ_START, 3'd3, 16'd0, 1'b0);
        send_fields(REQ_START, 3'd4, 16'hFFFF, 1'b0);
        send_fields(REQ_START, 3'd5, 16'hFFFF, 1'b1);
        repeat (40) send_fields(REQ_TICK, 3'd0, 16'd0, 1'b0);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            send_fields(REQ_STOP, ch[2:0], 16'd0, 1'b0);
        end
    endtask

    task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct);
        for (int unsigned n = 0; n < items; n++) begin
            send_req(random_req());
            pause_sender(idle_pct);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("response with no transaction outstanding");
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.fired_mask !== want.fired_mask) begin
                    report_mismatch($sformatf("fired_mask %b, expected %b",
                                              o_rsp.fired_mask, want.fired_mask));
                end
                if (o_rsp.active_mask !== want.active_mask) begin
                    report_mismatch($sformatf("active_mask %b, expected %b",
                                              o_rsp.active_mask, want.active_mask));
                end
                if (o_rsp.current_count !== want.current_count) begin
                    report_mismatch($sformatf("current_count %0d, expected %0d",
                                              o_rsp.current_count, want.current_count));
                end
            end
        end
    end

    initial begin
        clear_timer_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unused_requests();
        test_expiry_modes();
        wait_drained();
        test_long_durations();
        wait_drained();
        test_random_traffic(530, 35);
        test_random_traffic(530, 77);
        test_random_traffic(540, 0);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_rsp.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
